[rtl/core/spherical_lens_remap_unit_assert.svh]
// Assertion macros for the lens remap RTL.
`ifndef SPHERICAL_LENS_REMAP_UNIT_ASSERT_SVH
`define SPHERICAL_LENS_REMAP_UNIT_ASSERT_SVH

// Property must hold on every clock edge outside reset.
`define SLR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent implies consequent on the next clock edge.
`define SLR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/slr_pkg.sv]
`timescale 1ns / 1ps
package slr_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 20;

   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 13;
   localparam int ADDR_BITS = 24;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LENS_LEFT    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LENS_TOP     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LENS_SIZE    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ZOOM         = 3'd5;

   // Quotient width of the lens ratio.
   localparam int QUO_BITS = 2 * FRAC_BITS_DEF + 1;

endpackage

[rtl/core/slr_div_cell.sv]
`timescale 1ns / 1ps
// One restoring division step: shifts the remainder, subtracts the divisor when it fits.
module slr_div_cell
   import slr_pkg::*;
#(
   parameter int REM_BITS = 24,
   parameter int Q_BITS   = 41
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                vld_i,
   input  logic [REM_BITS-1:0] rem_i,
   input  logic [REM_BITS-1:0] den_i,
   input  logic [Q_BITS-1:0]   quo_i,
   output logic                vld_o,
   output logic [REM_BITS-1:0] rem_o,
   output logic [REM_BITS-1:0] den_o,
   output logic [Q_BITS-1:0]   quo_o
);

   logic [REM_BITS:0]   sh;
   logic                ge;
   logic                vld_ff;
   logic [REM_BITS-1:0] rem_ff, den_ff;
   logic [Q_BITS-1:0]   quo_ff;

   assign sh = {rem_i, 1'b0};
   assign ge = (sh >= {1'b0, den_i});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= ge ? REM_BITS'(sh - {1'b0, den_i}) : sh[REM_BITS-1:0];
         den_ff <= den_i;
         quo_ff <= {quo_i[Q_BITS-2:0], ge};
      end
   end

   assign vld_o = vld_ff;
   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign quo_o = quo_ff;

endmodule

[rtl/core/slr_sqrt_cell.sv]
`timescale 1ns / 1ps
// One digit-recurrence step of the integer square root.
module slr_sqrt_cell
   import slr_pkg::*;
#(
   parameter int N_BITS = 42,
   parameter int R_BITS = 21
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              vld_i,
   input  logic [N_BITS-1:0] num_i,
   input  logic [R_BITS+1:0] rem_i,
   input  logic [R_BITS-1:0] root_i,
   output logic              vld_o,
   output logic [N_BITS-1:0] num_o,
   output logic [R_BITS+1:0] rem_o,
   output logic [R_BITS-1:0] root_o
);

   logic [R_BITS+1:0] trial, cand;
   logic              ok;
   logic              vld_ff;
   logic [N_BITS-1:0] num_ff;
   logic [R_BITS+1:0] rem_ff;
   logic [R_BITS-1:0] root_ff;

   // bring down the next two radicand bits and try root*4+1
   assign trial = {rem_i[R_BITS-1:0], num_i[N_BITS-1 -: 2]};
   assign cand  = {root_i, 2'b01};
   assign ok    = (trial >= cand);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff  <= {num_i[N_BITS-3:0], 2'b00};
         rem_ff  <= ok ? trial - cand : trial;
         root_ff <= {root_i[R_BITS-2:0], ok};
      end
   end

   assign vld_o  = vld_ff;
   assign num_o  = num_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

[rtl/core/spherical_lens_remap_unit.sv]
`timescale 1ns / 1ps
// Channel | Ports                                           | Direction
// req     | req_valid req_ready req_pixel_x req_pixel_y     | in
// rsp     | rsp_valid rsp_ready rsp_source_address          | out
//         | rsp_in_lens rsp_address_clamped                 |
// csr     | csr_write csr_index csr_data                    | in
//
// One item per clock while results are taken; each item passes through the
// chain of divider cells followed by the chain of square root cells.
// Reset is synchronous; it empties the chain and restores register defaults.
// The whole chain holds while the output register holds an untaken item.
module spherical_lens_remap_unit
   import slr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [COORD_BITS-1:0]    req_pixel_x,
   input  logic [COORD_BITS-1:0]    req_pixel_y,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [ADDR_BITS-1:0]     rsp_source_address,
   output logic                     rsp_in_lens,
   output logic                     rsp_address_clamped,
   input  logic                     csr_write,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int DIV_STEPS = 2 * FRAC_BITS;
   localparam int QB        = DIV_STEPS + 1;   // quotient bits kept (one spare)
   localparam int NB        = QB + (QB % 2);   // radicand bits, even
   localparam int SQ_STEPS  = NB / 2;
   localparam int RB        = SQ_STEPS;
   localparam int REMB      = 25;              // holds zoom^2 + r^2 < 2^23, shifted
   localparam int SB        = 26;              // signed position width
   localparam int TAG       = 2 * SB + 1;

   logic adv;

   // configuration
   logic [12:0] fw_ff, fh_ff, size_ff_w;
   logic signed [12:0] left_ff, top_ff;
   logic [11:0] size_ff;
   logic [7:0]  zoom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff   <= 13'd640;
         fh_ff   <= 13'd480;
         left_ff <= 13'sd160;
         top_ff  <= 13'sd120;
         size_ff <= 12'd120;
         zoom_ff <= 8'd30;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  fw_ff   <= csr_data;
            CSR_FRAME_HEIGHT: fh_ff   <= csr_data;
            CSR_LENS_LEFT:    left_ff <= csr_data;
            CSR_LENS_TOP:     top_ff  <= csr_data;
            CSR_LENS_SIZE:    size_ff <= csr_data[11:0];
            CSR_ZOOM:         zoom_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end
   assign size_ff_w = {1'b0, size_ff};

   // stage A: relative position
   logic signed [SB-1:0] r_s, u_a, v_a;
   logic a_vld_ff;
   logic signed [SB-1:0] u_ff, v_ff, r_ff, px_ff, py_ff;

   assign r_s = SB'(size_ff_w >> 1);
   assign u_a = SB'(req_pixel_x) - (SB'(left_ff) + r_s);
   assign v_a = SB'(req_pixel_y) - (SB'(top_ff) + r_s);

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else if (adv) a_vld_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff  <= u_a;
         v_ff  <= v_a;
         r_ff  <= r_s;
         px_ff <= SB'(req_pixel_x);
         py_ff <= SB'(req_pixel_y);
      end
   end

   // stage B: lens-square test and squares
   logic b_vld_ff, b_box_ff;
   logic [SB-1:0] usq_ff, vsq_ff, rsq_ff, z2_ff;
   logic signed [SB-1:0] bu_ff, bv_ff, bpx_ff, bpy_ff;
   logic box;
   assign box = (u_ff > -r_ff) && (u_ff < r_ff) && (v_ff > -r_ff) && (v_ff < r_ff);

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (adv) b_vld_ff <= a_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         b_box_ff <= box;
         usq_ff   <= box ? SB'($signed(u_ff[12:0]) * $signed(u_ff[12:0])) : '0;
         vsq_ff   <= box ? SB'($signed(v_ff[12:0]) * $signed(v_ff[12:0])) : '0;
         rsq_ff   <= SB'(r_ff[11:0] * r_ff[11:0]);
         z2_ff    <= SB'(zoom_ff * zoom_ff);
         bu_ff    <= u_ff;
         bv_ff    <= v_ff;
         bpx_ff   <= px_ff;
         bpy_ff   <= py_ff;
      end
   end

   // stage C: disc test and divisor
   logic c_vld_ff, c_in_ff;
   logic [REMB-1:0] c_z2_ff, c_d_ff;
   logic signed [SB-1:0] cu_ff, cv_ff, cpx_ff, cpy_ff;
   logic signed [SB:0] disc_gap;
   assign disc_gap = $signed({1'b0, usq_ff}) + $signed({1'b0, vsq_ff})
                   - $signed({1'b0, rsq_ff});

   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else if (adv) c_vld_ff <= b_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c_in_ff <= b_box_ff && disc_gap[SB];
         c_z2_ff <= REMB'(z2_ff);
         c_d_ff  <= REMB'(z2_ff) + REMB'(-disc_gap);
         cu_ff   <= bu_ff;
         cv_ff   <= bv_ff;
         cpx_ff  <= bpx_ff;
         cpy_ff  <= bpy_ff;
      end
   end

   // divider chain
   logic [DIV_STEPS:0]  dv;
   logic [REMB-1:0]     drem [DIV_STEPS+1];
   logic [REMB-1:0]     dden [DIV_STEPS+1];
   logic [QB-1:0]       dquo [DIV_STEPS+1];
   assign dv[0]   = c_vld_ff;
   assign drem[0] = c_z2_ff;
   assign dden[0] = c_d_ff;
   assign dquo[0] = '0;

   // side tags travel beside the chain
   localparam int TOTAL = DIV_STEPS + SQ_STEPS;
   logic [TAG+2*SB-1:0] tag_ff [TOTAL];
   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= {c_in_ff, cu_ff, cv_ff, cpx_ff, cpy_ff};
         for (int i = 1; i < TOTAL; i++) tag_ff[i] <= tag_ff[i-1];
      end
   end

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      slr_div_cell #(.REM_BITS(REMB), .Q_BITS(QB)) u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .vld_i(dv[g]), .rem_i(drem[g]), .den_i(dden[g]), .quo_i(dquo[g]),
         .vld_o(dv[g+1]), .rem_o(drem[g+1]), .den_o(dden[g+1]), .quo_o(dquo[g+1])
      );
   end

   // square root chain
   logic [SQ_STEPS:0] sv;
   logic [NB-1:0]     snum  [SQ_STEPS+1];
   logic [RB+1:0]     srem  [SQ_STEPS+1];
   logic [RB-1:0]     sroot [SQ_STEPS+1];
   assign sv[0]    = dv[DIV_STEPS];
   assign snum[0]  = NB'(dquo[DIV_STEPS]);
   assign srem[0]  = '0;
   assign sroot[0] = '0;

   for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
      slr_sqrt_cell #(.N_BITS(NB), .R_BITS(RB)) u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .vld_i(sv[g]), .num_i(snum[g]), .rem_i(srem[g]), .root_i(sroot[g]),
         .vld_o(sv[g+1]), .num_o(snum[g+1]), .rem_o(srem[g+1]), .root_o(sroot[g+1])
      );
   end

   // stage E: axis products
   logic e_vld_ff, e_in_ff;
   logic signed [SB-1:0] eu_ff, ev_ff, epx_ff, epy_ff;
   logic [12:0] au, av;
   logic [RB+13:0] pu_ff, pv_ff;
   logic t_in;
   logic signed [SB-1:0] t_u, t_v, t_px, t_py;
   assign {t_in, t_u, t_v, t_px, t_py} = tag_ff[TOTAL-1];
   assign au = t_u[SB-1] ? 13'(-t_u) : t_u[12:0];
   assign av = t_v[SB-1] ? 13'(-t_v) : t_v[12:0];

   always_ff @(posedge clock) begin
      if (reset) e_vld_ff <= 1'b0;
      else if (adv) e_vld_ff <= sv[SQ_STEPS];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         e_in_ff <= t_in;
         pu_ff   <= (RB+14)'(au) * (RB+14)'(sroot[SQ_STEPS]);
         pv_ff   <= (RB+14)'(av) * (RB+14)'(sroot[SQ_STEPS]);
         eu_ff   <= t_u;
         ev_ff   <= t_v;
         epx_ff  <= t_px;
         epy_ff  <= t_py;
      end
   end

   // stage F: shifts and row product
   logic f_vld_ff, f_in_ff;
   logic [RB+13:0] au_sh, av_sh;
   logic [RB+13:0] mu, mv;
   logic signed [SB-1:0] dxs, dys, sy;
   logic signed [2*SB-1:0] row_ff;
   logic signed [SB-1:0] fx_ff;
   assign au_sh = (RB+14)'(eu_ff[SB-1] ? 13'(-eu_ff) : eu_ff[12:0]) << FRAC_BITS;
   assign av_sh = (RB+14)'(ev_ff[SB-1] ? 13'(-ev_ff) : ev_ff[12:0]) << FRAC_BITS;
   assign mu = (au_sh - pu_ff) >> FRAC_BITS;
   assign mv = (av_sh - pv_ff) >> FRAC_BITS;
   assign dxs = !e_in_ff ? '0 : eu_ff[SB-1] ? SB'(mu) : -SB'(mu);
   assign dys = !e_in_ff ? '0 : ev_ff[SB-1] ? SB'(mv) : -SB'(mv);
   assign sy  = epy_ff + dys;

   always_ff @(posedge clock) begin
      if (reset) f_vld_ff <= 1'b0;
      else if (adv) f_vld_ff <= e_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         f_in_ff <= e_in_ff;
         row_ff  <= sy * $signed({{(SB-13){1'b0}}, fw_ff});
         fx_ff   <= epx_ff + dxs;
      end
   end

   // stage G: clamp into the output register
   logic signed [2*SB:0] addr;
   logic [25:0] area, lim;
   logic [ADDR_BITS-1:0] addr_out;
   logic clamp;
   assign addr = (2*SB+1)'(row_ff) + (2*SB+1)'(fx_ff);
   assign area = 26'(fw_ff * fh_ff);
   assign lim  = (area > 26'h1000000) ? 26'h1000000 : area;
   always_comb begin
      clamp    = 1'b0;
      addr_out = addr[ADDR_BITS-1:0];
      if (lim == '0) begin
         clamp = 1'b1; addr_out = '0;
      end else if (addr[2*SB]) begin
         clamp = 1'b1; addr_out = '0;
      end else if (addr >= (2*SB+1)'(lim)) begin
         clamp = 1'b1; addr_out = ADDR_BITS'(lim - 26'd1);
      end
   end

   logic o_vld_ff, o_in_ff, o_cl_ff;
   logic [ADDR_BITS-1:0] o_addr_ff;
   always_ff @(posedge clock) begin
      if (reset) o_vld_ff <= 1'b0;
      else if (adv) o_vld_ff <= f_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         o_in_ff   <= f_in_ff;
         o_cl_ff   <= clamp;
         o_addr_ff <= addr_out;
      end
   end

   // hold the chain while a result waits
   assign adv = !o_vld_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = o_vld_ff;
   assign rsp_source_address = o_addr_ff;
   assign rsp_in_lens = o_in_ff;
   assign rsp_address_clamped = o_cl_ff;

`include "spherical_lens_remap_unit_assert.svh"
   `SLR_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_source_address), "result changed while stalled")
   `SLR_ASSERT(a_ready, req_ready == (!rsp_valid || rsp_ready), "ready does not follow output stage")
   `SLR_ASSERT_NEXT(a_flow, adv && f_vld_ff, o_vld_ff, "item lost at output stage")
   `SLR_ASSERT(a_clamp, !(rsp_valid && rsp_address_clamped == 1'b0 && rsp_source_address >= ADDR_BITS'(lim) && lim != '0 && lim != 26'h1000000), "unclamped address beyond frame")

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import slr_pkg::*;

   typedef struct {
      logic [ADDR_BITS-1:0] address;
      logic                 in_lens;
      logic                 clamped;
   } remap_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [11:0]              req_pixel_x = '0;
   logic [11:0]              req_pixel_y = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [ADDR_BITS-1:0]     rsp_source_address;
   logic                     rsp_in_lens;
   logic                     rsp_address_clamped;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // register copy used by the predictor
   logic [12:0]        frame_w;
   logic [12:0]        frame_h;
   logic signed [12:0] lens_l;
   logic signed [12:0] lens_t;
   logic [11:0]        lens_sz;
   logic [7:0]         zoom_v;

   remap_type remap_q[$];
   int     fail_count = 0;
   int     idle_cycles = 0;
   int     rsp_taken = 0;
   int     stall_left = 0;
   bit     no_idle = 0;

   spherical_lens_remap_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_source_address(rsp_source_address), .rsp_in_lens(rsp_in_lens),
      .rsp_address_clamped(rsp_address_clamped),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bit_v;
      root = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= root + bit_v) begin
            n -= root + bit_v;
            root = (root >> 1) + bit_v;
         end else begin
            root >>= 1;
         end
         bit_v >>= 2;
      end
      return root;
   endfunction

   // truncated a - a*s, signed opposite to the offset from the centre
   function automatic longint lens_shift(longint w, longint unsigned ratio);
      longint unsigned a;
      longint unsigned mag;
      a = (w < 0) ? -w : w;
      mag = ((a << FRAC_BITS_DEF) - a * ratio) >> FRAC_BITS_DEF;
      return (w < 0) ? longint'(mag) : -longint'(mag);
   endfunction

   function automatic remap_type predict_remap(logic [11:0] px, logic [11:0] py);
      remap_type res;
      longint r, u, v, dx, dy, disc_gap, area, addr;
      longint unsigned z2, ratio;
      r = lens_sz >> 1;
      u = longint'(px) - (longint'(lens_l) + r);
      v = longint'(py) - (longint'(lens_t) + r);
      dx = 0;
      dy = 0;
      res.in_lens = 1'b0;
      res.clamped = 1'b0;
      if (u > -r && u < r && v > -r && v < r) begin
         disc_gap = u * u + v * v - r * r;
         if (disc_gap < 0) begin
            z2 = zoom_v * zoom_v;
            ratio = int_sqrt((z2 << (2 * FRAC_BITS_DEF)) / (z2 - disc_gap));
            dx = lens_shift(u, ratio);
            dy = lens_shift(v, ratio);
            res.in_lens = 1'b1;
         end
      end
      addr = (longint'(py) + dy) * longint'(frame_w) + longint'(px) + dx;
      area = longint'(frame_w) * longint'(frame_h);
      if (area > (64'd1 << 24)) area = 64'd1 << 24;
      if (area == 0 || addr < 0) begin
         addr = 0;
         res.clamped = 1'b1;
      end else if (addr >= area) begin
         addr = area - 1;
         res.clamped = 1'b1;
      end
      res.address = addr[ADDR_BITS-1:0];
      return res;
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 14);
   endfunction

   // result side: check at the falling edge, the item is taken at the next rising one
   always @(negedge clock) begin
      remap_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1;
            idle_cycles = 0;
            if (remap_q.size() == 0) begin
               $display("%0t unexpected item: got address %h in_lens %b clamped %b",
                        $time, rsp_source_address, rsp_in_lens, rsp_address_clamped);
               fail_count++;
            end else begin
               want = remap_q.pop_front();
               if (rsp_source_address !== want.address) begin
                  $display("%0t source_address: expected %h got %h",
                           $time, want.address, rsp_source_address);
                  fail_count++;
               end
               if (rsp_in_lens !== want.in_lens) begin
                  $display("%0t in_lens: expected %b got %b", $time, want.in_lens, rsp_in_lens);
                  fail_count++;
               end
               if (rsp_address_clamped !== want.clamped) begin
                  $display("%0t address_clamped: expected %b got %b",
                           $time, want.clamped, rsp_address_clamped);
                  fail_count++;
               end
            end
         end else if (!(req_valid && req_ready)) begin
            idle_cycles++;
         end else begin
            idle_cycles = 0;
         end
         if (idle_cycles >= 3000) begin
            $display("%0t watchdog: no item accepted", $time);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (rsp_taken) begin
         rsp_taken = 0;
         n = draw_gap();
         stall_left = n;
         rsp_ready <= (n == 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= (stall_left == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // called just after a rising edge; returns just after the accepting edge
   task automatic send_pixel(logic [11:0] px, logic [11:0] py);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      remap_q.push_back(predict_remap(px, py));
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (remap_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_reg(logic [CSR_IDX_BITS-1:0] idx, logic [12:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:  frame_w = value;
         CSR_FRAME_HEIGHT: frame_h = value;
         CSR_LENS_LEFT:    lens_l = value;
         CSR_LENS_TOP:     lens_t = value;
         CSR_LENS_SIZE:    lens_sz = value[11:0];
         CSR_ZOOM:         zoom_v = value[7:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [12:0] w, logic [12:0] h, logic [12:0] l, logic [12:0] t,
                            logic [12:0] sz, logic [12:0] z);
      drain();
      set_reg(CSR_FRAME_WIDTH, w);
      set_reg(CSR_FRAME_HEIGHT, h);
      set_reg(CSR_LENS_LEFT, l);
      set_reg(CSR_LENS_TOP, t);
      set_reg(CSR_LENS_SIZE, sz);
      set_reg(CSR_ZOOM, z);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      logic [11:0] cx, cy, rr;
      cx = 220;
      cy = 180;
      rr = 60;
      no_idle = 1;
      send_pixel(cx, cy);
      send_pixel(cx + 12'd10, cy - 12'd20);
      send_pixel(cx - rr, cy);        // on the disc edge: no shift
      send_pixel(cx + rr - 12'd1, cy);
      send_pixel(cx - 12'd40, cy + 12'd40);   // in the square and inside the disc
      send_pixel(0, 0);
      send_pixel(639, 479);
      send_pixel(12'hFFF, 12'hFFF);   // beyond the frame: clamp high
      no_idle = 0;
      send_pixel(cx - 12'd30, cy + 12'd25);
   endtask

   task automatic test_register_extremes();
      configure(13'd1, 13'd1, 13'd0, 13'd0, 13'd2048, 13'd5);
      send_pixel(0, 0);
      send_pixel(1, 1);
      configure(13'd4096, 13'd4096, -13'sd2048, -13'sd2048, 13'd2048, 13'd200);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(0, 0);
      configure(13'd4096, 13'd4096, 13'd1000, 13'd1000, 13'd4095, 13'd255);
      send_pixel(2000, 2047);
      send_pixel(3000, 1500);
      configure(13'd0, 13'd480, 13'd160, 13'd120, 13'd120, 13'd30);   // empty frame
      send_pixel(220, 180);
      configure(13'd640, 13'd480, 13'd100, 13'd100, 13'd40, 13'd0);   // zoom zero
      send_pixel(110, 125);
      send_pixel(135, 101);
      configure(13'd640, 13'd480, 13'd4095, 13'd4095, 13'd1, 13'd30); // radius zero
      send_pixel(4095, 4095);
      configure(13'd640, 13'd480, 13'd300, 13'd10, 13'd0, 13'd30);
      send_pixel(300, 10);
      configure(13'd64, 13'd48, -13'sd30, -13'sd30, 13'd100, 13'd20); // lens square reaches past the frame corner
      send_pixel(0, 0);
      send_pixel(3, 1);
      send_pixel(19, 19);
   endtask

   task automatic test_random_frames();
      logic [12:0] w, h, l, t, sz, z;
      logic [11:0] px, py;
      int sel, lo_x, lo_y, span;
      for (int phase = 0; phase < 12; phase++) begin
         sel = $urandom_range(0, 9);
         w = 13'((sel < 7) ? $urandom_range(1, 800) : $urandom_range(1, 4096));
         h = 13'((sel < 7) ? $urandom_range(1, 600) : $urandom_range(1, 4096));
         sz = 13'((sel == 9) ? $urandom_range(0, 4095) : $urandom_range(0, 300));
         if (sel == 8) sz = 13'($urandom_range(0, 2048));
         z = 13'((sel == 0) ? $urandom_range(0, 255) : $urandom_range(5, 200));
         if (sel == 5) begin
            l = 13'($urandom);
            t = 13'($urandom);
         end else begin
            l = 13'($urandom_range(0, w) - sz / 2);
            t = 13'($urandom_range(0, h) - sz / 2);
         end
         configure(w, h, l, t, sz, z);
         no_idle = (phase % 4 == 3);
         for (int k = 0; k < 85; k++) begin
            sel = $urandom_range(0, 19);
            span = (sz == 0) ? 1 : sz;
            lo_x = $signed(l);
            lo_y = $signed(t);
            if (sel < 12) begin
               // aim into the lens square
               px = 12'(lo_x + $urandom_range(0, span - 1));
               py = 12'(lo_y + $urandom_range(0, span - 1));
            end else if (sel < 17) begin
               px = 12'($urandom_range(0, w - 1));
               py = 12'($urandom_range(0, h - 1));
            end else begin
               px = 12'($urandom);
               py = 12'($urandom);
            end
            send_pixel(px, py);
         end
      end
      no_idle = 0;
   endtask

   initial begin
      frame_w = 13'd640;
      frame_h = 13'd480;
      lens_l = 13'sd160;
      lens_t = 13'sd120;
      lens_sz = 12'd120;
      zoom_v = 8'd30;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_extremes();
      test_random_frames();
      drain();
      repeat (80) @(posedge clock);
      if (fail_count == 0 && remap_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
